@@ rtl/bfs_pkg.sv @@
`timescale 1ns / 1ps
package bfs_pkg;

	// Node slots held in storage and the width of a node number.
	localparam int SLOTS = 64;
	localparam int NW = 6;
	// Queue pointers and path length count up to SLOTS itself.
	localparam int PW = 7;

	// Function codes of an input beat.
	localparam logic [2:0] FUNC_ADD_NODE = 3'd0;
	localparam logic [2:0] FUNC_ADD_EDGE = 3'd1;
	localparam logic [2:0] FUNC_DEL_EDGE = 3'd2;
	localparam logic [2:0] FUNC_PATH     = 3'd3;
	localparam logic [2:0] FUNC_HOPS     = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Adjacency row address select.
	localparam logic [1:0] ADJ_A   = 2'd0;
	localparam logic [1:0] ADJ_B   = 2'd1;
	localparam logic [1:0] ADJ_CUR = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       ld_item;
		logic       set_present;
		logic       adj_rd;
		logic       adj_wr;
		logic [1:0] adj_sel;
		logic       srch_init;
		logic       q_rd;
		logic       ld_cur;
		logic       ld_pend;
		logic       enq;
		logic       ld_lvl;
		logic       dec_left;
		logic       walk_init;
		logic       walk_push;
		logic       par_rd;
		logic       walk_next;
		logic       out_init;
		logic       pb_rd;
		logic       idx_dec;
		logic       out_path;
		logic       out_single;
		logic [1:0] single_code;
	} bfs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] func;
		logic       a_ok;
		logic       a_pres;
		logic       b_pres;
		logic       head_lt_tail;
		logic       head_lt_lvl;
		logic       left_zero;
		logic       cur_eq_b;
		logic       pend_any;
		logic       node_eq_s;
		logic       idx_zero;
		logic       out_busy;
	} bfs_stat_t;

endpackage

@@ rtl/bfs_ctrl.sv @@
`timescale 1ns / 1ps
module bfs_ctrl
	import bfs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  bfs_stat_t st,
	output bfs_cmd_t  cmd
);

	typedef enum logic [4:0] {
		IDLE, DISPATCH, SINGLE,
		E_RD_A, E_WR_A, E_RD_B, E_WR_B,
		DEQ, D_CUR, D_CHK,
		H_CHK, H_T, H_DEQ, H_CUR,
		X_ADJ, X_PEND, X_ENQ,
		W_INIT, W_PUSH, W_NEXT,
		O_START, O_RD, O_LD
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] code_q, code_d;

	assign in_stall = (state_q != IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d = DISPATCH;
				end
			end
			DISPATCH: begin
				unique case (st.func) inside
					FUNC_ADD_NODE: begin
						cmd.set_present = st.a_ok;
						code_d  = st.a_ok ? ST_OK : ST_INVALID;
						state_d = SINGLE;
					end
					FUNC_ADD_EDGE, FUNC_DEL_EDGE: begin
						if (st.a_pres && st.b_pres) begin
							state_d = E_RD_A;
						end else begin
							code_d  = ST_INVALID;
							state_d = SINGLE;
						end
					end
					FUNC_PATH, FUNC_HOPS: begin
						if (st.a_pres) begin
							cmd.srch_init = 1'b1;
							state_d = (st.func == FUNC_PATH) ? DEQ : H_CHK;
						end else begin
							code_d  = ST_INVALID;
							state_d = SINGLE;
						end
					end
					default: state_d = IDLE;
				endcase
			end
			SINGLE: begin
				if (!st.out_busy) begin
					cmd.out_single  = 1'b1;
					cmd.single_code = code_q;
					state_d = IDLE;
				end
			end
			// Edge update: read, modify and write both rows in turn.
			E_RD_A: begin
				cmd.adj_rd  = 1'b1;
				cmd.adj_sel = ADJ_A;
				state_d = E_WR_A;
			end
			E_WR_A: begin
				cmd.adj_wr  = 1'b1;
				cmd.adj_sel = ADJ_A;
				state_d = E_RD_B;
			end
			E_RD_B: begin
				cmd.adj_rd  = 1'b1;
				cmd.adj_sel = ADJ_B;
				state_d = E_WR_B;
			end
			E_WR_B: begin
				cmd.adj_wr  = 1'b1;
				cmd.adj_sel = ADJ_B;
				code_d  = ST_OK;
				state_d = SINGLE;
			end
			// Shortest path: dequeue until the target comes out or the queue runs empty.
			DEQ: begin
				if (st.head_lt_tail) begin
					cmd.q_rd = 1'b1;
					state_d = D_CUR;
				end else begin
					code_d  = ST_NOT_FOUND;
					state_d = SINGLE;
				end
			end
			D_CUR: begin
				cmd.ld_cur = 1'b1;
				state_d = D_CHK;
			end
			D_CHK: begin
				state_d = st.cur_eq_b ? W_INIT : X_ADJ;
			end
			// Hop query: one level of the queue per remaining hop.
			H_CHK: begin
				if (!st.head_lt_tail) begin
					code_d  = ST_NOT_FOUND;
					state_d = SINGLE;
				end else if (st.left_zero) begin
					cmd.q_rd = 1'b1;
					state_d = H_T;
				end else begin
					cmd.ld_lvl = 1'b1;
					state_d = H_DEQ;
				end
			end
			H_T: begin
				cmd.ld_cur = 1'b1;
				state_d = W_INIT;
			end
			H_DEQ: begin
				if (st.head_lt_lvl) begin
					cmd.q_rd = 1'b1;
					state_d = H_CUR;
				end else begin
					cmd.dec_left = 1'b1;
					state_d = H_CHK;
				end
			end
			H_CUR: begin
				cmd.ld_cur = 1'b1;
				state_d = X_ADJ;
			end
			// Expansion of the current node, one neighbor per cycle.
			X_ADJ: begin
				cmd.adj_rd  = 1'b1;
				cmd.adj_sel = ADJ_CUR;
				state_d = X_PEND;
			end
			X_PEND: begin
				cmd.ld_pend = 1'b1;
				state_d = X_ENQ;
			end
			X_ENQ: begin
				if (st.pend_any) begin
					cmd.enq = 1'b1;
				end else begin
					state_d = (st.func == FUNC_HOPS) ? H_DEQ : DEQ;
				end
			end
			// Parent walk from the found node back to the start.
			W_INIT: begin
				cmd.walk_init = 1'b1;
				state_d = W_PUSH;
			end
			W_PUSH: begin
				cmd.walk_push = 1'b1;
				if (st.node_eq_s) begin
					state_d = O_START;
				end else begin
					cmd.par_rd = 1'b1;
					state_d = W_NEXT;
				end
			end
			W_NEXT: begin
				cmd.walk_next = 1'b1;
				state_d = W_PUSH;
			end
			// Path output, start node first.
			O_START: begin
				cmd.out_init = 1'b1;
				state_d = O_RD;
			end
			O_RD: begin
				if (!st.out_busy) begin
					cmd.pb_rd = 1'b1;
					state_d = O_LD;
				end
			end
			O_LD: begin
				cmd.out_path = 1'b1;
				if (st.idx_zero) begin
					state_d = IDLE;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d = O_RD;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

@@ rtl/bfs_dpath.sv @@
`timescale 1ns / 1ps
module bfs_dpath
	import bfs_pkg::*;
#(
	parameter int NODE_COUNT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bfs_cmd_t      cmd,
	output bfs_stat_t     st,
	input  logic [2:0]    func,
	input  logic [NW-1:0] node_a,
	input  logic [NW-1:0] node_b,
	input  logic [NW-1:0] hops,
	output logic [NW-1:0] path_node,
	output logic [1:0]    status,
	output logic          last,
	output logic          out_valid,
	input  logic          out_stall
);

	logic [2:0]       func_q;
	logic [NW-1:0]    a_q, b_q, left_q, cur_q, node_q, idx_q;
	logic [SLOTS-1:0] present_q, visited_q, row_valid_q, pend_q;
	logic [PW-1:0]    head_q, tail_q, lvl_q, plen_q;

	logic [SLOTS-1:0] adj_mem [SLOTS];
	logic [NW-1:0]    par_mem [SLOTS];
	logic [NW-1:0]    que_mem [SLOTS];
	logic [NW-1:0]    pb_mem  [SLOTS];
	logic [SLOTS-1:0] adj_rdata_q;
	logic             adj_rvalid_q;
	logic [NW-1:0]    par_rdata_q, que_rdata_q, pb_rdata_q;

	logic [NW-1:0]    adj_addr, other, low_idx;
	logic [SLOTS-1:0] adj_row, adj_wdata;

	// Lowest set bit of a pending neighbor word.
	function automatic logic [NW-1:0] lowest(input logic [SLOTS-1:0] v);
		logic [NW-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) r = NW'(i);
		end
		return r;
	endfunction

	always_comb begin
		case (cmd.adj_sel)
			ADJ_A:   adj_addr = a_q;
			ADJ_B:   adj_addr = b_q;
			default: adj_addr = cur_q;
		endcase
		other     = (cmd.adj_sel == ADJ_A) ? b_q : a_q;
		adj_row   = adj_rvalid_q ? adj_rdata_q : '0;
		adj_wdata = adj_row;
		adj_wdata[other] = (func_q == FUNC_ADD_EDGE);
		low_idx   = lowest(pend_q);
	end

	assign st.func         = func_q;
	assign st.a_ok         = (32'(a_q) < NODE_COUNT);
	assign st.a_pres       = present_q[a_q];
	assign st.b_pres       = present_q[b_q];
	assign st.head_lt_tail = (head_q < tail_q);
	assign st.head_lt_lvl  = (head_q < lvl_q);
	assign st.left_zero    = (left_q == '0);
	assign st.cur_eq_b     = (cur_q == b_q);
	assign st.pend_any     = (pend_q != '0);
	assign st.node_eq_s    = (node_q == a_q);
	assign st.idx_zero     = (idx_q == '0);
	assign st.out_busy     = out_valid;

	// Node present mask, row valid bits and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			row_valid_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.set_present) present_q[a_q] <= 1'b1;
			if (cmd.adj_wr) row_valid_q[adj_addr] <= 1'b1;
			if (cmd.out_single || cmd.out_path) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Search registers and the output beat payload.
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			func_q <= func;
			a_q    <= node_a;
			b_q    <= node_b;
			left_q <= hops;
		end
		if (cmd.srch_init) begin
			visited_q <= SLOTS'(1) << a_q;
			head_q <= '0;
			tail_q <= PW'(1);
		end
		if (cmd.q_rd) head_q <= head_q + PW'(1);
		if (cmd.ld_cur) cur_q <= que_rdata_q;
		if (cmd.ld_pend) pend_q <= adj_row & present_q & ~visited_q;
		if (cmd.enq) begin
			visited_q[low_idx] <= 1'b1;
			pend_q[low_idx]    <= 1'b0;
			tail_q <= tail_q + PW'(1);
		end
		if (cmd.ld_lvl) lvl_q <= tail_q;
		if (cmd.dec_left) left_q <= left_q - NW'(1);
		if (cmd.walk_init) begin
			node_q <= cur_q;
			plen_q <= '0;
		end
		if (cmd.walk_push) plen_q <= plen_q + PW'(1);
		if (cmd.walk_next) node_q <= par_rdata_q;
		if (cmd.out_init) idx_q <= NW'(plen_q - PW'(1));
		if (cmd.idx_dec) idx_q <= idx_q - NW'(1);
		if (cmd.out_single) begin
			path_node <= '0;
			status    <= cmd.single_code;
			last      <= 1'b1;
		end else if (cmd.out_path) begin
			path_node <= pb_rdata_q;
			status    <= ST_OK;
			last      <= (idx_q == '0);
		end
	end

	// Adjacency rows.
	always_ff @(posedge clk) begin
		if (cmd.adj_wr) adj_mem[adj_addr] <= adj_wdata;
		if (cmd.adj_rd) begin
			adj_rdata_q  <= adj_mem[adj_addr];
			adj_rvalid_q <= row_valid_q[adj_addr];
		end
	end

	// Parent links and the search queue.
	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			par_mem[a_q] <= a_q;
			que_mem[0]   <= a_q;
		end else if (cmd.enq) begin
			par_mem[low_idx]         <= cur_q;
			que_mem[tail_q[NW-1:0]]  <= low_idx;
		end
		if (cmd.par_rd) par_rdata_q <= par_mem[node_q];
		if (cmd.q_rd) que_rdata_q <= que_mem[head_q[NW-1:0]];
	end

	// Path buffer, filled target first and read back start first.
	always_ff @(posedge clk) begin
		if (cmd.walk_push) pb_mem[plen_q[NW-1:0]] <= node_q;
		if (cmd.pb_rd) pb_rdata_q <= pb_mem[idx_q];
	end

endmodule

@@ rtl/bfs_graph_path_engine_core.sv @@
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// input    in_valid / in_stall  func, node_a, node_b, hops
// output   out_valid/out_stall  path_node, status, last
//
// A graph update holds in_stall until its result beat is loaded; an edge between two
// present nodes first reads and writes both adjacency rows. A path query dequeues nodes
// until the target comes out, enqueuing each new neighbor; a hop query expands the queue
// level by level. The parent walk then fills the path buffer, and each path beat waits
// while the output stalls; in_stall is high until the last beat is loaded.
// Reset clears the node mask, row valid bits, output valid and the controller.
module bfs_graph_path_engine_core
	import bfs_pkg::*;
#(
	parameter int NODE_COUNT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    func,
	input  logic [NW-1:0] node_a,
	input  logic [NW-1:0] node_b,
	input  logic [NW-1:0] hops,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [NW-1:0] path_node,
	output logic [1:0]    status,
	output logic          last
);

	bfs_cmd_t  cmd;
	bfs_stat_t st;

	bfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bfs_dpath #(
		.NODE_COUNT (NODE_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.func      (func),
		.node_a    (node_a),
		.node_b    (node_b),
		.hops      (hops),
		.path_node (path_node),
		.status    (status),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

`ifndef SYNTHESIS
	// An accepted item keeps the input side busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// Error and not-found beats always close their item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last)
		else $error("error beat without last mark");

	// Error beats carry node zero.
	a_err_node: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> path_node == '0)
		else $error("error beat with a nonzero node");
`endif

endmodule
